FILE: sv/rpn_stack_calculator_assert.svh
// Assertion macros for the calculator
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define RPNC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rpnc assertion failed");
`define RPNC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rpnc assertion failed");
`else
`define RPNC_ASSERT(lbl, prop)
`define RPNC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: sv/rpnc_pkg.sv
`timescale 1ns / 1ps
package rpnc_pkg;
  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int PTR_W = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int DEPTH_W = 5;
  localparam int CNT_W = $clog2(DATA_W);

  localparam logic [3:0] OP_PUSH = 4'd0;
  localparam logic [3:0] OP_DUP = 4'd1;
  localparam logic [3:0] OP_PEEK = 4'd2;
  localparam logic [3:0] OP_POP = 4'd3;
  localparam logic [3:0] OP_ADD = 4'd4;
  localparam logic [3:0] OP_SUB = 4'd5;
  localparam logic [3:0] OP_MUL = 4'd6;
  localparam logic [3:0] OP_DIV = 4'd7;
  localparam logic [3:0] OP_MOD = 4'd8;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER = 2'd2;
  localparam logic [1:0] ST_DIVZ = 2'd3;
endpackage

FILE: sv/rpnc_ram.sv
`timescale 1ns / 1ps
module rpnc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

FILE: sv/rpn_stack_calculator.sv
`timescale 1ns / 1ps
// Reverse-Polish integer stack calculator with a 16-entry stack of 32-bit
// values held in a RAM. One result beat follows each input beat, and the
// input stalls until the block is back in idle. A push, an unknown opcode
// and any item that fails its stack check go straight to the result hand-off;
// dup, peek and pop first read the top of stack; divide or modulo by zero
// also reads the second operand; add, subtract, multiply, divide and modulo
// add to both reads the bit-serial datapath, which retires one operand bit per
// cycle (serial add/subtract, shift-add multiply, restoring divide), then a
// write-back and the hand-off to the output register. A finished
// result waits in the output register, and while it is stalled there the
// next result cannot leave the block.
`include "rpn_stack_calculator_assert.svh"
module rpn_stack_calculator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [3:0]                  in_opcode,
  input  logic signed [31:0]          in_operand_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          out_shown_value,
  output logic                        out_shown_valid,
  output logic [1:0]                  out_status,
  output logic [rpnc_pkg::DEPTH_W-1:0] out_stack_depth
);
  import rpnc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_TOP, S_SEC, S_CALC, S_FIX, S_FIN} state_t;

  state_t             state_r;
  logic [3:0]         op_r;
  logic [PTR_W-1:0]   sp_r;
  logic [DATA_W-1:0]  a_r, b_r, res_r, rem_r, shown_r;
  logic               c_r, nl_r, nr_r, valid_r;
  logic [1:0]         status_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               out_valid_r;
  logic [DATA_W-1:0]  out_shown_r;
  logic               out_shown_valid_r;
  logic [1:0]         out_status_r;
  logic [DEPTH_W-1:0] out_depth_r;

  logic [PTR_W-1:0]   sp_m1, sp_m2;
  logic               we;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [DATA_W-1:0]  wdata, rdata, res_fix;
  logic               bb, sbit, cy_nxt;
  logic [DATA_W:0]    sh, diff;
  logic               accept, out_free;

  assign sp_m1 = sp_r - PTR_W'(1);
  assign sp_m2 = sp_r - PTR_W'(2);
  assign accept = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign bb = b_r[0] ^ (op_r == OP_SUB);
  assign sbit = a_r[0] ^ bb ^ c_r;
  assign cy_nxt = (a_r[0] & bb) | (a_r[0] & c_r) | (bb & c_r);
  assign sh = {rem_r, a_r[DATA_W-1]};
  assign diff = sh - {1'b0, b_r};

  always_comb begin
    unique case (op_r)
      OP_DIV:  res_fix = (nl_r ^ nr_r) ? (DATA_W'(0) - a_r) : a_r;
      OP_MOD:  res_fix = nl_r ? (DATA_W'(0) - rem_r) : rem_r;
      default: res_fix = res_r;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = sp_r[ADDR_W-1:0];
    wdata = rdata;
    raddr = sp_m1[ADDR_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        we = accept && (in_opcode == OP_PUSH) && (sp_r < PTR_W'(STACK_DEPTH));
        wdata = in_operand_value;
      end
      S_TOP: begin
        raddr = sp_m2[ADDR_W-1:0];
        we = (op_r == OP_DUP);
      end
      S_FIX: begin
        we = 1'b1;
        waddr = sp_m2[ADDR_W-1:0];
        wdata = res_fix;
      end
      default: ;
    endcase
  end

  rpnc_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r <= '0;
      out_valid_r <= 1'b0;
      out_depth_r <= '0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r <= in_opcode;
            shown_r <= '0;
            valid_r <= 1'b0;
            status_r <= ST_OK;
            state_r <= S_FIN;
            priority case (in_opcode)
              OP_PUSH: begin
                if (sp_r >= PTR_W'(STACK_DEPTH)) begin
                  status_r <= ST_OVER;
                end else begin
                  sp_r <= sp_r + PTR_W'(1);
                end
              end
              OP_DUP: begin
                if (sp_r == '0) begin
                  status_r <= ST_UNDER;
                end else if (sp_r >= PTR_W'(STACK_DEPTH)) begin
                  status_r <= ST_OVER;
                end else begin
                  state_r <= S_TOP;
                end
              end
              OP_PEEK, OP_POP: begin
                if (sp_r == '0) begin
                  status_r <= ST_UNDER;
                end else begin
                  state_r <= S_TOP;
                end
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
                if (sp_r < PTR_W'(2)) begin
                  status_r <= ST_UNDER;
                end else begin
                  state_r <= S_TOP;
                end
              end
              default: ;
            endcase
          end
        end
        S_TOP: begin
          b_r <= rdata;
          state_r <= S_FIN;
          priority case (op_r)
            OP_DUP: sp_r <= sp_r + PTR_W'(1);
            OP_PEEK: begin
              shown_r <= rdata;
              valid_r <= 1'b1;
            end
            OP_POP: begin
              shown_r <= rdata;
              valid_r <= 1'b1;
              sp_r <= sp_m1;
            end
            default: state_r <= S_SEC;
          endcase
        end
        S_SEC: begin
          cnt_r <= '0;
          res_r <= '0;
          rem_r <= '0;
          c_r <= (op_r == OP_SUB);
          nl_r <= rdata[DATA_W-1];
          nr_r <= b_r[DATA_W-1];
          a_r <= rdata;
          state_r <= S_CALC;
          if ((op_r == OP_DIV) || (op_r == OP_MOD)) begin
            if (b_r == '0) begin
              status_r <= ST_DIVZ;
              state_r <= S_FIN;
            end
            a_r <= rdata[DATA_W-1] ? (DATA_W'(0) - rdata) : rdata;
            b_r <= b_r[DATA_W-1] ? (DATA_W'(0) - b_r) : b_r;
          end
        end
        S_CALC: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(DATA_W - 1)) begin
            state_r <= S_FIX;
          end
          priority case (op_r)
            OP_ADD, OP_SUB: begin
              res_r <= {sbit, res_r[DATA_W-1:1]};
              c_r <= cy_nxt;
              a_r <= a_r >> 1;
              b_r <= b_r >> 1;
            end
            OP_MUL: begin
              if (b_r[0]) begin
                res_r <= res_r + a_r;
              end
              a_r <= a_r << 1;
              b_r <= b_r >> 1;
            end
            default: begin
              if (!diff[DATA_W]) begin
                rem_r <= diff[DATA_W-1:0];
              end else begin
                rem_r <= sh[DATA_W-1:0];
              end
              a_r <= {a_r[DATA_W-2:0], !diff[DATA_W]};
            end
          endcase
        end
        S_FIX: begin
          sp_r <= sp_m1;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_shown_r <= shown_r;
            out_shown_valid_r <= valid_r;
            out_status_r <= status_r;
            out_depth_r <= DEPTH_W'(sp_r);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_shown_value = out_shown_r;
  assign out_shown_valid = out_shown_valid_r;
  assign out_status = out_status_r;
  assign out_stack_depth = out_depth_r;

  `RPNC_ASSERT(a_sp_bound, sp_r <= PTR_W'(STACK_DEPTH))
  `RPNC_ASSERT(a_accept_busy, in_valid && !in_stall |=> state_r != S_IDLE)
  `RPNC_ASSERT(a_calc_len, state_r == S_CALC && cnt_r == CNT_W'(DATA_W - 1) |=> state_r == S_FIX)
  `RPNC_ASSERT(a_fin_out, state_r == S_FIN && out_free |=> out_valid_r && state_r == S_IDLE)
  `RPNC_ASSERT(a_shown_ok, out_valid_r && out_shown_valid_r |-> out_status_r == ST_OK)
endmodule
